// File: design/sorted_set_intersection_defines.svh
// assertion macros for the sorted set intersection checker
`ifndef SORTED_SET_INTERSECTION_DEFINES_SVH
`define SORTED_SET_INTERSECTION_DEFINES_SVH
// concurrent assertion on the checker clock with reset disable
`define SSI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`endif

// File: design/ssi_pkg.sv
// shared types and constants of the sorted set intersection block
package ssi_pkg;
    localparam int VAL_W = 32;
    localparam logic OP_A = 1'b0;
    localparam logic OP_B = 1'b1;
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             opcode;
        logic             last;
    } t_item;
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
        logic             empty;
        logic             overflow;
    } t_res;
endpackage

// File: design/ssi_front.sv
// front end: input skid queue of two words
module ssi_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ssi_pkg::t_item i_item,
    output logic          o_valid,
    input  logic          i_ready,
    output ssi_pkg::t_item o_item
);
    ssi_pkg::t_item r_q [2];
    logic           r_rd, r_wr;
    logic [1:0]     r_cnt;
    logic           push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= i_item;
        if (!i_rst_n) begin
            r_rd <= 1'b0;
            r_wr <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// File: design/ssi_back.sv
// back end: set storage and ordered intersection scan
module ssi_back #(
    parameter int MAX_ELEMS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ssi_pkg::t_item i_item,
    output logic          o_valid,
    input  logic          i_ready,
    output ssi_pkg::t_res  o_res
);
    localparam int CW = $clog2(MAX_ELEMS + 1);
    localparam int IW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam logic [2:0] S_LOAD = 3'd0, S_AMIN = 3'd1, S_BSCAN = 3'd2, S_EMIT = 3'd3,
                           S_DONE = 3'd4;
    localparam logic [ssi_pkg::VAL_W-1:0] BIAS = 32'h8000_0000;

    logic [ssi_pkg::VAL_W-1:0] r_amem [MAX_ELEMS];
    logic [ssi_pkg::VAL_W-1:0] r_bmem [MAX_ELEMS];
    logic [ssi_pkg::VAL_W-1:0] r_ad, r_bd;
    logic [ssi_pkg::VAL_W-1:0] r_prev, r_best, r_pval;
    logic [CW-1:0] r_ca, r_cb, r_i, r_j;
    logic          r_drop, r_hp, r_found, r_pend, r_rdv;
    logic [2:0]    r_st;
    logic          r_ov;
    ssi_pkg::t_res r_out, n_out;
    logic          r_ov_valid;
    logic [ssi_pkg::VAL_W-1:0] akey, bkey;
    logic          full_a, full_b, ld_a, ld_b, out_free, ld_out;

    assign full_a   = (r_ca == CW'(MAX_ELEMS));
    assign full_b   = (r_cb == CW'(MAX_ELEMS));
    assign o_ready  = (r_st == S_LOAD);
    assign o_valid  = r_ov_valid;
    assign o_res    = r_out;
    assign ld_a     = o_ready && i_valid && i_item.opcode == ssi_pkg::OP_A && !full_a;
    assign ld_b     = o_ready && i_valid && i_item.opcode == ssi_pkg::OP_B && !full_b;
    // biased keys compare in signed order as unsigned
    assign akey     = r_ad ^ BIAS;
    assign bkey     = r_bd ^ BIAS;
    assign out_free = !r_ov_valid || i_ready;

    // set memories, one write and one registered read each per cycle
    always_ff @(posedge i_clk) begin
        if (ld_a) r_amem[r_ca[IW-1:0]] <= i_item.value;
        if (ld_b) r_bmem[r_cb[IW-1:0]] <= i_item.value;
        r_ad <= r_amem[r_i[IW-1:0]];
        r_bd <= r_bmem[r_j[IW-1:0]];
    end

    // one match is held back so the closing word can carry last
    always_comb begin
        ld_out = 1'b0;
        n_out  = r_out;
        if (r_st == S_EMIT && r_pend && out_free) begin
            ld_out = 1'b1;
            n_out  = '{value: r_pval, last: 1'b0, empty: 1'b0, overflow: r_ov};
        end else if (r_st == S_DONE && out_free) begin
            ld_out = 1'b1;
            if (r_pend) n_out = '{value: r_pval, last: 1'b1, empty: 1'b0, overflow: r_ov};
            else n_out = '{value: '0, last: 1'b1, empty: 1'b1, overflow: r_ov};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_LOAD;
            r_ca <= '0;
            r_cb <= '0;
            r_drop <= 1'b0;
            r_pend <= 1'b0;
            r_rdv <= 1'b0;
            r_ov_valid <= 1'b0;
        end else begin
            r_ov_valid <= ld_out || (r_ov_valid && !i_ready);
            if (ld_out) r_out <= n_out;
            unique case (r_st)
                S_LOAD: if (i_valid) begin
                    if (i_item.opcode == ssi_pkg::OP_A) begin
                        if (full_a) r_drop <= 1'b1;
                        else r_ca <= r_ca + 1'b1;
                    end else begin
                        if (full_b) r_drop <= 1'b1;
                        else r_cb <= r_cb + 1'b1;
                        if (i_item.last) begin
                            r_ov <= r_drop || full_b;
                            r_hp <= 1'b0;
                            r_pend <= 1'b0;
                            r_i <= '0;
                            r_found <= 1'b0;
                            r_rdv <= 1'b0;
                            r_st <= S_AMIN;
                        end
                    end
                end
                // smallest A key above the previous candidate
                S_AMIN: begin
                    if (r_i != r_ca) begin
                        r_i <= r_i + 1'b1;
                        r_rdv <= 1'b1;
                    end else begin
                        r_rdv <= 1'b0;
                    end
                    if (r_rdv && (!r_hp || akey > r_prev) && (!r_found || akey < r_best)) begin
                        r_best <= akey;
                        r_found <= 1'b1;
                    end
                    if (r_i == r_ca && !r_rdv) begin
                        r_j <= '0;
                        r_st <= r_found ? S_BSCAN : S_DONE;
                    end
                end
                // look for the candidate in B
                S_BSCAN: begin
                    if (r_rdv && bkey == r_best) begin
                        r_prev <= r_best;
                        r_hp <= 1'b1;
                        r_rdv <= 1'b0;
                        r_st <= S_EMIT;
                    end else if (r_j == r_cb && !r_rdv) begin
                        r_prev <= r_best;
                        r_hp <= 1'b1;
                        r_i <= '0;
                        r_found <= 1'b0;
                        r_st <= S_AMIN;
                    end else if (r_j != r_cb) begin
                        r_j <= r_j + 1'b1;
                        r_rdv <= 1'b1;
                    end else begin
                        r_rdv <= 1'b0;
                    end
                end
                S_EMIT: if (!r_pend || out_free) begin
                    r_pend <= 1'b1;
                    r_pval <= r_best ^ BIAS;
                    r_i <= '0;
                    r_found <= 1'b0;
                    r_st <= S_AMIN;
                end
                S_DONE: if (out_free) begin
                    r_ca <= '0;
                    r_cb <= '0;
                    r_drop <= 1'b0;
                    r_pend <= 1'b0;
                    r_st <= S_LOAD;
                end
                default: r_st <= S_LOAD;
            endcase
        end
    end
endmodule

// File: design/sorted_set_intersection.sv
// Sorted set intersection.
// Input stream: tdata = value, tuser = opcode (0 set A, 1 set B), tlast ends set B.
// Output stream: tdata = value_res, tuser = {overflow, empty_res}, tlast = last_res.
// Loading takes one word per cycle while no scan runs: A and B are written to memories, words pass
// a two word input queue, so a word is registered in the queue before it is written to a set.
// The word marked last on B starts a scan: each pass reads all of A for the smallest value
// above the previous candidate, then reads B for it; a match then passes through the emit
// state. No input is taken while a run lasts.
// Common values leave in ascending order, each one held until the next match is
// found or the scan ends, so the final match carries tlast. With no common value
// one empty word (value 0) with tlast is sent.
// Reset (i_rst_n low, synchronous) clears counts, drop flag and queues.
// When the receiver stalls, the result register holds and the scan waits at the next match;
// the two word input queue fills and then drops tready.
module sorted_set_intersection #(
    parameter int MAX_ELEMS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // value
    input  logic        s_axis_tuser,  // opcode
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // value_res
    output logic [1:0]  m_axis_tuser,  // {overflow, empty_res}
    output logic        m_axis_tlast
);
    ssi_pkg::t_item in_item, q_item;
    ssi_pkg::t_res  res;
    logic q_valid, q_ready;

    assign in_item = '{value: s_axis_tdata, opcode: s_axis_tuser, last: s_axis_tlast};

    ssi_front u_front (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_item(in_item), .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );
    ssi_back #(.MAX_ELEMS(MAX_ELEMS)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );
    assign m_axis_tdata = res.value;
    assign m_axis_tuser = {res.overflow, res.empty};
    assign m_axis_tlast = res.last;
endmodule

// File: design/ssi_checker.sv
// port level checker for the sorted set intersection block
`include "sorted_set_intersection_defines.svh"
module ssi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    `SSI_ASSERT(a_empty_zero, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 32'd0, "empty word with data")
    `SSI_ASSERT(a_empty_last, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast, "empty word not last")
    `SSI_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled word changed")
endmodule
bind sorted_set_intersection ssi_checker u_ssi_checker (.*);

// File: bench/tb_sorted_set_intersection.sv
// testbench for the sorted set intersection block: random stream traffic and a predictor
`timescale 1ns / 100ps

module tb_sorted_set_intersection;

    localparam int CAP       = 64;
    localparam int MAX_CYC   = 2000000;
    localparam int DRAIN_CYC = 300;
    localparam int N_ITEMS   = 330;
    localparam int N_FIXED   = 16 + 2 * CAP + 5;

    // tracks the loaded sets and holds the intersection words still due
    class intersect_board;
        logic [ssi_pkg::VAL_W-1:0] set_a[CAP];
        logic [ssi_pkg::VAL_W-1:0] set_b[CAP];
        int     n_a;
        int     n_b;
        logic   dropped;
        ssi_pkg::t_res due_q[$];
        int     errors;

        function new();
            n_a = 0;
            n_b = 0;
            dropped = 1'b0;
            errors = 0;
        endfunction

        function void note_item(logic [ssi_pkg::VAL_W-1:0] v, logic op, logic lst);
            int   keys[$];
            int   k, j, tmp;
            int   n_res;
            bit   hit;
            ssi_pkg::t_res r;
            n_res = 0;
            if (op == ssi_pkg::OP_A) begin
                if (n_a < CAP) begin
                    set_a[n_a] = v;
                    n_a++;
                end else begin
                    dropped = 1'b1;
                end
                return;
            end
            if (n_b < CAP) begin
                set_b[n_b] = v;
                n_b++;
            end else begin
                dropped = 1'b1;
            end
            if (!lst) return;
            for (k = 0; k < n_a; k++) keys.push_back(int'(set_a[k]));
            // insertion sort, signed ascending
            for (k = 1; k < keys.size(); k++) begin
                tmp = keys[k];
                j = k;
                while (j > 0 && keys[j-1] > tmp) begin
                    keys[j] = keys[j-1];
                    j--;
                end
                keys[j] = tmp;
            end
            r.value = '0;
            for (k = 0; k < keys.size(); k++) begin
                if (k > 0 && keys[k] == keys[k-1]) continue;
                hit = 0;
                for (j = 0; j < n_b; j++)
                    if (set_b[j] == keys[k]) hit = 1;
                if (hit) begin
                    r.value = keys[k];
                    r.last = 1'b0;
                    r.empty = 1'b0;
                    r.overflow = dropped;
                    due_q.push_back(r);
                    n_res++;
                end
            end
            if (n_res == 0) begin
                r.value = '0;
                r.last = 1'b1;
                r.empty = 1'b1;
                r.overflow = dropped;
                due_q.push_back(r);
            end else begin
                due_q[due_q.size()-1].last = 1'b1;
            end
            n_a = 0;
            n_b = 0;
            dropped = 1'b0;
        endfunction

        function void check_word(ssi_pkg::t_res got);
            ssi_pkg::t_res want;
            if (due_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: value=%0d last=%0b empty=%0b ovf=%0b",
                             $signed(got.value), got.last, got.empty, got.overflow);
                return;
            end
            want = due_q.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp value=%0d last=%0b empty=%0b ovf=%0b, ",
                              "got value=%0d last=%0b empty=%0b ovf=%0b"},
                             $signed(want.value), want.last, want.empty, want.overflow,
                             $signed(got.value), got.last, got.empty, got.overflow);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // value
    logic        s_axis_tuser;   // opcode
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // value_res
    logic [1:0]  m_axis_tuser;   // {overflow, empty_res}
    logic        m_axis_tlast;

    intersect_board board;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  n_sent;
    int  cyc;

    sorted_set_intersection #(.MAX_ELEMS(CAP)) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        board = new();
        recv_stall_pct = 0;
        send_idle_pct = 0;
        m_axis_tready = 1'b0;
    end

    // receiver side stall pattern
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk) begin
        ssi_pkg::t_res w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            w.value = m_axis_tdata;
            w.last = m_axis_tlast;
            w.empty = m_axis_tuser[0];
            w.overflow = m_axis_tuser[1];
            board.check_word(w);
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > MAX_CYC) begin
            $display("FAIL");
            $finish;
        end
    end

    // caller is at a falling edge; returns at a falling edge after acceptance
    task automatic send_item(logic [31:0] v, logic op, logic lst);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = v;
        s_axis_tuser = op;
        s_axis_tlast = lst;
        taken = 0;
        while (!taken) begin
            @(posedge i_clk);
            taken = s_axis_tready;
        end
        board.note_item(v, op, lst);
        n_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_value(int mode);
        case (mode)
            0: return 32'($urandom_range(12)) - 32'd6;
            1: return $urandom;
            default: begin
                case ($urandom_range(4))
                    0: return 32'h7fffffff;
                    1: return 32'h80000000;
                    2: return 32'h0;
                    3: return 32'hffffffff;
                    default: return 32'h1;
                endcase
            end
        endcase
    endfunction

    // one full run: set A, then set B ending with last
    task automatic send_run(int na, int nb);
        int mode;
        int k;
        mode = $urandom_range(9) < 6 ? 0 : ($urandom_range(1) ? 1 : 2);
        for (k = 0; k < na; k++)
            send_item(pick_value(mode), ssi_pkg::OP_A, $urandom_range(9) == 0);
        for (k = 0; k < nb; k++)
            send_item(pick_value(mode), ssi_pkg::OP_B, k == nb - 1);
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (board.due_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
    endtask

    initial begin
        int ph;
        int na, nb;
        cyc = 0;
        n_sent = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ssi_pkg::OP_A;
        s_axis_tlast = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // extremes, incl. the max positive value as an ordinary element
        send_item(32'h7fffffff, ssi_pkg::OP_A, 1'b0);
        send_item(32'h80000000, ssi_pkg::OP_A, 1'b0);
        send_item(32'h00000000, ssi_pkg::OP_A, 1'b0);
        send_item(32'hffffffff, ssi_pkg::OP_A, 1'b0);
        send_item(32'hffffffff, ssi_pkg::OP_B, 1'b0);
        send_item(32'h7fffffff, ssi_pkg::OP_B, 1'b0);
        send_item(32'h00000005, ssi_pkg::OP_B, 1'b1);
        // empty set A
        send_item(32'h00000003, ssi_pkg::OP_B, 1'b1);
        // duplicates and last flag on set A
        send_item(32'h00000005, ssi_pkg::OP_A, 1'b0);
        send_item(32'h00000005, ssi_pkg::OP_A, 1'b1);
        send_item(32'h00000002, ssi_pkg::OP_A, 1'b0);
        send_item(32'h00000002, ssi_pkg::OP_B, 1'b0);
        send_item(32'h00000005, ssi_pkg::OP_B, 1'b0);
        send_item(32'h00000005, ssi_pkg::OP_B, 1'b1);
        // disjoint sets
        send_item(32'h00000001, ssi_pkg::OP_A, 1'b0);
        send_item(32'h00000002, ssi_pkg::OP_B, 1'b1);
        // sender holds off until everything is back
        wait_drained();

        // both sets over capacity; dropped last on B still starts the run
        send_run(CAP + 3, CAP + 2);

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            while (n_sent < N_FIXED + (ph + 1) * ((N_ITEMS - N_FIXED) / 4)) begin
                na = $urandom_range(10);
                nb = $urandom_range(10, 1);
                send_run(na, nb);
            end
        end

        wait_drained();
        if (board.errors == 0 && board.due_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/ssi_pkg.sv
design/ssi_front.sv
design/ssi_back.sv
design/sorted_set_intersection.sv
design/ssi_checker.sv
bench/tb_sorted_set_intersection.sv
